### hdl/sparse_row_hash_accumulator_macros.svh
// Assertion helpers for the sparse row accumulator.
`ifndef SPARSE_ROW_HASH_ACCUMULATOR_MACROS_SVH
`define SPARSE_ROW_HASH_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SRHA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srha check failed");
`define SRHA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srha check failed");
`else
`define SRHA_ASSERT_IMP(label, ante, cons)
`define SRHA_ASSERT_NXT(label, ante, cons)
`endif
`endif

### hdl/srha_pkg.sv
`default_nettype none
package srha_pkg;
    // Row capacity (one cell per distinct column) and field widths.
    localparam int MAX_DISTINCT = 64;
    localparam int COLUMN_BITS  = 24;
    localparam int SUM_W        = 32;
    localparam int PROD_W       = 2 * SUM_W;
    localparam int FRAC_BITS    = 16;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic                    entry_valid;
        logic signed [SUM_W-1:0] multiplier;
        logic [COLUMN_BITS-1:0]  column;
        logic signed [SUM_W-1:0] b_value;
        logic                    row_end;
    } t_in;

    typedef struct packed {
        logic [COLUMN_BITS-1:0]  out_column;
        logic signed [SUM_W-1:0] out_sum;
        logic                    last;
        logic                    overflow;
    } t_out;

    // Product term travelling down the chain.
    typedef struct packed {
        logic                    vld;
        logic [COLUMN_BITS-1:0]  column;
        logic signed [SUM_W-1:0] prod;
    } t_term;

    // Contents of one cell.
    typedef struct packed {
        logic                    occ;
        logic [COLUMN_BITS-1:0]  column;
        logic signed [SUM_W-1:0] sum;
    } t_slot;

    // Saturating add of two Q16.16 values.
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction
endpackage
`default_nettype wire

### hdl/srha_mul.sv
`default_nettype none
module srha_mul (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  wire srha_pkg::t_in     i_word,
    output srha_pkg::t_term        o_term,
    output logic                   o_busy
);
    import srha_pkg::*;

    logic                     r_v1;
    logic [COLUMN_BITS-1:0]   r_col1;
    logic signed [PROD_W-1:0] r_prod1;
    t_term                    r_term;
    logic signed [PROD_W-FRAC_BITS-1:0] w_q;
    logic signed [SUM_W-1:0]  w_sat;

    // Stage 1: full product; zero multipliers and empty items carry no term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid && i_word.entry_valid && (i_word.multiplier != '0);
        end
        r_col1  <= i_word.column;
        r_prod1 <= PROD_W'(i_word.multiplier) * PROD_W'(i_word.b_value);
    end

    // Floor shift (arithmetic) and saturation
    always_comb begin
        w_q = r_prod1[PROD_W-1:FRAC_BITS];
        if (w_q[PROD_W-FRAC_BITS-1:SUM_W-1] != {(PROD_W-FRAC_BITS-SUM_W+1){1'b0}} &&
            w_q[PROD_W-FRAC_BITS-1:SUM_W-1] != {(PROD_W-FRAC_BITS-SUM_W+1){1'b1}}) begin
            w_sat = w_q[PROD_W-FRAC_BITS-1] ? SUM_MIN : SUM_MAX;
        end else begin
            w_sat = w_q[SUM_W-1:0];
        end
    end

    // Stage 2: term register feeding cell 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term.vld <= 1'b0;
        end else begin
            r_term.vld <= r_v1;
        end
        r_term.column <= r_col1;
        r_term.prod   <= w_sat;
    end

    assign o_term = r_term;
    assign o_busy = r_v1 | r_term.vld;
endmodule
`default_nettype wire

### hdl/srha_cell.sv
`default_nettype none
module srha_cell (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire srha_pkg::t_term   i_term,
    input  wire                    i_shift,
    input  wire srha_pkg::t_slot   i_next,
    output srha_pkg::t_term        o_term,
    output srha_pkg::t_slot        o_slot
);
    import srha_pkg::*;

    t_slot r_slot, n_slot;
    t_term r_term, n_term;

    // On shift the cell loads the next cell's slot; else match adds, empty cell claims, otherwise the term moves on
    always_comb begin
        n_slot     = r_slot;
        n_term     = i_term;
        n_term.vld = 1'b0;
        if (i_shift) begin
            n_slot = i_next;
        end else if (i_term.vld) begin
            if (!r_slot.occ) begin
                n_slot.occ    = 1'b1;
                n_slot.column = i_term.column;
                n_slot.sum    = i_term.prod;
            end else if (r_slot.column == i_term.column) begin
                n_slot.sum = sat_add(r_slot.sum, i_term.prod);
            end else begin
                n_term.vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.occ <= 1'b0;
            r_term.vld <= 1'b0;
        end else begin
            r_slot.occ <= n_slot.occ;
            r_term.vld <= n_term.vld;
        end
        r_slot.column <= n_slot.column;
        r_slot.sum    <= n_slot.sum;
        r_term.column <= n_term.column;
        r_term.prod   <= n_term.prod;
    end

    assign o_term = r_term;
    assign o_slot = r_slot;
endmodule
`default_nettype wire

### hdl/sparse_row_hash_accumulator.sv
// Sparse row accumulator: row merge of a Gustavson sparse matrix product.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
// product term: multiplier, B column and B value, plus entry_valid and
// row_end. Terms are multiplied (two stages) and then walk a chain of
// MAX_DISTINCT cells, one cell per cycle; each cell holds one distinct
// column in first-insertion order and adds, claims or forwards the term.
// Within a row a word is taken every cycle. After a row_end word the input
// stalls until the row is out: the multiplier and the chain drain, then one
// result word per cycle, while the receiver is ready, leaves through the
// output register (o_out_valid / i_out_ready / o_out_word), the chain
// shifting toward cell 0. An empty row emits column 0, sum 0. Columns past
// capacity are dropped and flag overflow on every word of that row.
// A stalled receiver holds the output word and freezes emission.
// Synchronous reset empties all cells and clears the output valid and row state.
`default_nettype none
`include "sparse_row_hash_accumulator_macros.svh"
module sparse_row_hash_accumulator (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire srha_pkg::t_in     i_in_word,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output srha_pkg::t_out         o_out_word
);
    import srha_pkg::*;

    t_term w_term [0:MAX_DISTINCT];
    t_slot w_slot [0:MAX_DISTINCT];
    logic  [MAX_DISTINCT-1:0] w_cell_busy;
    logic  w_mul_busy, w_busy, w_accept, w_emit, w_shift, w_last;
    logic  r_pend, r_drop, r_ovld;
    t_out  r_out;

    assign o_in_ready = !r_pend;
    assign w_accept   = i_in_valid && o_in_ready;

    srha_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_word  (i_in_word),
        .o_term  (w_term[0]),
        .o_busy  (w_mul_busy)
    );

    assign w_slot[MAX_DISTINCT] = '0;

    // Cell chain
    for (genvar g = 0; g < MAX_DISTINCT; g++) begin : g_cell
        srha_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_term  (w_term[g]),
            .i_shift (w_shift),
            .i_next  (w_slot[g+1]),
            .o_term  (w_term[g+1]),
            .o_slot  (w_slot[g])
        );
        assign w_cell_busy[g] = w_term[g+1].vld;
    end

    // Emission control
    assign w_busy  = w_mul_busy || (|w_cell_busy);
    assign w_emit  = r_pend && !w_busy && (!r_ovld || i_out_ready);
    assign w_shift = w_emit && w_slot[0].occ;
    assign w_last  = !w_slot[1].occ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_drop <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (w_accept && i_in_word.row_end) begin
                r_pend <= 1'b1;
            end
            // a term leaving the last cell found no room
            if (w_term[MAX_DISTINCT].vld) begin
                r_drop <= 1'b1;
            end
            if (w_emit) begin
                r_ovld <= 1'b1;
                if (w_last) begin
                    r_pend <= 1'b0;
                    r_drop <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
        if (w_emit) begin
            r_out.out_column <= w_slot[0].occ ? w_slot[0].column : '0;
            r_out.out_sum    <= w_slot[0].occ ? w_slot[0].sum : '0;
            r_out.last       <= w_last;
            r_out.overflow   <= r_drop;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_word  = r_out;

    `SRHA_ASSERT_IMP(a_shift_idle, w_shift, !w_busy)
    `SRHA_ASSERT_IMP(a_prefix, w_slot[1].occ, w_slot[0].occ)
    `SRHA_ASSERT_NXT(a_last_done, w_emit && w_last, !r_pend && r_ovld)
endmodule
`default_nettype wire
